// File: src/stl_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the source text lexer.
// Depends on nothing; stl_step and the lexer top level import it.
package stl_pkg;

  // Default size of the largest source the counters are built for.
  localparam longint unsigned STL_SOURCE_BYTES = 64'd16777216;

  // Size of the result list, which bounds the tokens one source byte can release, and the width of a count of them.
  localparam int STL_MAX_RESULTS = 6;
  localparam int STL_COUNT_W     = $clog2(STL_MAX_RESULTS + 1);
  localparam int STL_INDEX_W     = $clog2(STL_MAX_RESULTS);

  typedef enum logic [3:0] {
    MODE_MARK,
    MODE_IDLE,
    MODE_SLASH,
    MODE_LINE,
    MODE_BLOCK,
    MODE_STRING,
    MODE_OPER,
    MODE_WORD,
    MODE_WORDDOT
  } mode_t;

  typedef enum logic [2:0] {
    KIND_WORD,
    KIND_DELIM,
    KIND_STRING,
    KIND_END,
    KIND_ERROR
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } stl_in_t;

  typedef struct packed {
    kind_t       token_kind;
    logic [23:0] start_offset;
    logic [24:0] token_length;
    logic [24:0] start_line;
    logic [24:0] start_column;
    logic        run_end;
  } stl_token_t;

  // Scanner control state; the position counters travel separately.
  typedef struct packed {
    mode_t      mode;
    logic [7:0] held_byte;
    logic       prev_digit;
    logic       prev_star;
    logic [1:0] mark_seen;
  } stl_ctl_t;

  localparam stl_ctl_t STL_CTL_RESET = '{
    mode:       MODE_MARK,
    held_byte:  8'h00,
    prev_digit: 1'b0,
    prev_star:  1'b0,
    mark_seen:  2'd0
  };

  // Counters stop at the smaller of the source size and 2^24.
  function automatic longint unsigned stl_count_cap(input longint unsigned source_bytes);
    return (source_bytes < 64'h1000000) ? source_bytes : 64'h1000000;
  endfunction

  function automatic int stl_count_width(input longint unsigned source_bytes);
    return $clog2(stl_count_cap(source_bytes) + 64'd1);
  endfunction

endpackage

// File: src/stl_chan_if.sv
`timescale 1ns / 1ps
// Valid/ready channel used for the byte input and the token output.
// The payload type is chosen per instance; no other dependencies.
interface stl_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/stl_step.sv
`timescale 1ns / 1ps
// Combinational scan step: next scanner state and the tokens released by one byte.
// Depends on stl_pkg for the state, token and input types.
module stl_step import stl_pkg::*; #(
  parameter longint unsigned SOURCE_BYTES = STL_SOURCE_BYTES
) (
  input  stl_in_t                                  item,
  input  stl_ctl_t                                 ctl,
  input  logic [stl_count_width(SOURCE_BYTES)-1:0] pos,
  input  logic [stl_count_width(SOURCE_BYTES)-1:0] line,
  input  logic [stl_count_width(SOURCE_BYTES)-1:0] col,
  input  logic [stl_count_width(SOURCE_BYTES)-1:0] tok_start,
  input  logic [stl_count_width(SOURCE_BYTES)-1:0] tok_line,
  input  logic [stl_count_width(SOURCE_BYTES)-1:0] tok_col,
  output stl_ctl_t                                 ctl_next,
  output logic [stl_count_width(SOURCE_BYTES)-1:0] pos_next,
  output logic [stl_count_width(SOURCE_BYTES)-1:0] line_next,
  output logic [stl_count_width(SOURCE_BYTES)-1:0] col_next,
  output logic [stl_count_width(SOURCE_BYTES)-1:0] tok_start_next,
  output logic [stl_count_width(SOURCE_BYTES)-1:0] tok_line_next,
  output logic [stl_count_width(SOURCE_BYTES)-1:0] tok_col_next,
  output stl_token_t                               results [STL_MAX_RESULTS],
  output logic [STL_COUNT_W-1:0]                   result_count
);

  localparam int CW    = stl_count_width(SOURCE_BYTES);
  localparam int SLOTS = 3;

  localparam logic [CW-1:0] CAP_V   = CW'(stl_count_cap(SOURCE_BYTES));
  localparam logic [CW:0]   LEN_CAP = (CW + 1)'(stl_count_cap(SOURCE_BYTES));
  localparam logic [CW:0]   LEN_ONE = (CW + 1)'(1);
  localparam logic [CW:0]   LEN_TWO = (CW + 1)'(2);

  localparam logic [7:0] MARK_0   = 8'hEF;
  localparam logic [7:0] MARK_1   = 8'hBB;
  localparam logic [7:0] MARK_2   = 8'hBF;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;

  function automatic logic is_ws(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch == CH_LF) || (ch == CH_CR) || (ch == CH_TAB);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= 8'h30) && (ch <= 8'h39);
  endfunction

  // The delimiter set: { } , . + - * / % = ( ) [ ] < > ! & | ^ ; :
  function automatic logic is_delim(input logic [7:0] ch);
    logic hit;
    case (ch)
      8'h7B, 8'h7D, 8'h2C, 8'h2E, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h3D, 8'h28,
      8'h29, 8'h5B, 8'h5D, 8'h3C, 8'h3E, 8'h21, 8'h26, 8'h7C, 8'h5E, 8'h3B,
      8'h3A: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic may_pair(input logic [7:0] ch);
    return (ch == CH_AMP) || (ch == CH_BAR) || (ch == CH_EQ) || (ch == CH_BANG) ||
           (ch == CH_LT) || (ch == CH_GT);
  endfunction

  function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
    return ((a == CH_AMP) && (b == CH_AMP)) || ((a == CH_BAR) && (b == CH_BAR)) ||
           ((a == CH_EQ) && (b == CH_EQ))   || ((a == CH_BANG) && (b == CH_EQ)) ||
           ((a == CH_LT) && (b == CH_EQ))   || ((a == CH_GT) && (b == CH_EQ)) ||
           ((a == CH_LT) && (b == CH_LT))   || ((a == CH_GT) && (b == CH_GT));
  endfunction

  function automatic logic [7:0] mark_byte(input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = MARK_0;
      2'd1:    b = MARK_1;
      default: b = MARK_2;
    endcase
    return b;
  endfunction

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v < CAP_V) ? v + CW'(1) : CAP_V;
  endfunction

  function automatic logic [CW:0] len_of(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return (CW + 1)'(a) - (CW + 1)'(b);
  endfunction

  function automatic logic [CW-1:0] dot_of(input logic [CW-1:0] p);
    return (p != '0) ? p - CW'(1) : '0;
  endfunction

  function automatic logic [CW-1:0] dcol_of(input logic [CW-1:0] c);
    return (c > CW'(1)) ? c - CW'(1) : CW'(1);
  endfunction

  function automatic logic [CW:0] len_before_dot(input logic [CW-1:0] dot,
                                                 input logic [CW-1:0] start);
    return (dot > start) ? len_of(dot, start) : '0;
  endfunction

  function automatic stl_token_t make_tok(input kind_t kind, input logic [CW-1:0] off,
                                          input logic [CW:0] len, input logic [CW-1:0] ln,
                                          input logic [CW-1:0] cl);
    stl_token_t  t;
    logic [24:0] off_w;
    logic [CW:0] len_c;
    off_w = 25'(off);
    len_c = (len > LEN_CAP) ? LEN_CAP : len;
    t.token_kind   = kind;
    t.start_offset = (off_w > 25'h0FFFFFF) ? 24'hFFFFFF : off_w[23:0];
    t.token_length = 25'(len_c);
    t.start_line   = 25'(ln);
    t.start_column = 25'(cl);
    t.run_end      = 1'b0;
    return t;
  endfunction

  logic [7:0] c;
  logic       do_feed;
  stl_ctl_t   p_ctl;
  logic [CW-1:0] p_pos, p_line, p_col, p_ts, p_tl, p_tc;
  stl_ctl_t   f_ctl;
  logic [CW-1:0] f_pos, f_line, f_col, f_ts, f_tl, f_tc;
  stl_token_t feed_tok [SLOTS];
  logic       feed_v   [SLOTS];
  stl_token_t fin_tok  [SLOTS];
  logic       fin_v    [SLOTS];

  assign c = item.data_byte;

  // Byte order mark check. A partial mark that breaks off is replayed as the
  // start of a word at offset 0, which is all three mark bytes can ever form.
  always_comb begin : mark_check
    logic [1:0] k;
    k       = (ctl.mark_seen > 2'd2) ? 2'd2 : ctl.mark_seen;
    p_ctl   = ctl;
    p_pos   = pos;
    p_line  = line;
    p_col   = col;
    p_ts    = tok_start;
    p_tl    = tok_line;
    p_tc    = tok_col;
    do_feed = 1'b1;
    if (ctl.mode == MODE_MARK) begin
      do_feed = 1'b0;
      if (c == mark_byte(k)) begin
        if (k == 2'd2) begin
          p_ctl.mode = MODE_IDLE;
          p_pos      = CW'(3);
        end else begin
          p_ctl.mark_seen = k + 2'd1;
          if (item.final_byte) begin
            p_ctl.mode       = MODE_WORD;
            p_ctl.prev_digit = 1'b0;
            p_ts   = '0;
            p_tl   = CW'(1);
            p_tc   = CW'(1);
            p_line = CW'(1);
            p_pos  = CW'(k) + CW'(1);
            p_col  = CW'(k) + CW'(2);
          end
        end
      end else begin
        do_feed = 1'b1;
        if (k != 2'd0) begin
          p_ctl.mode       = MODE_WORD;
          p_ctl.prev_digit = 1'b0;
          p_ts   = '0;
          p_tl   = CW'(1);
          p_tc   = CW'(1);
          p_line = CW'(1);
          p_pos  = CW'(k);
          p_col  = CW'(k) + CW'(1);
        end else begin
          p_ctl.mode = MODE_IDLE;
        end
      end
    end
  end

  // One byte through the scanner: the current mode may close a token and hand
  // the byte on to the idle rules in the same step.
  always_comb begin : feed_logic
    logic to_idle;
    to_idle = 1'b0;
    f_ctl   = p_ctl;
    f_pos   = p_pos;
    f_line  = p_line;
    f_col   = p_col;
    f_ts    = p_ts;
    f_tl    = p_tl;
    f_tc    = p_tc;
    for (int j = 0; j < SLOTS; j++) begin
      feed_tok[j] = '0;
      feed_v[j]   = 1'b0;
    end
    if (do_feed) begin
      case (p_ctl.mode)
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            f_ctl.mode = MODE_LINE;
          end else if (c == CH_STAR) begin
            f_ctl.mode      = MODE_BLOCK;
            f_ctl.prev_star = 1'b0;
          end else begin
            feed_v[0]   = 1'b1;
            feed_tok[0] = make_tok(KIND_DELIM, p_ts, LEN_ONE, p_tl, p_tc);
            to_idle     = 1'b1;
          end
        end
        MODE_LINE: begin
          if (c == CH_LF) begin
            f_ctl.mode = MODE_IDLE;
          end
        end
        MODE_BLOCK: begin
          if (p_ctl.prev_star && (c == CH_SLASH)) begin
            f_ctl.mode = MODE_IDLE;
          end else begin
            f_ctl.prev_star = (c == CH_STAR);
          end
        end
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            feed_v[0]   = 1'b1;
            feed_tok[0] = make_tok(KIND_STRING, p_ts, len_of(p_pos, p_ts) + LEN_ONE,
                                   p_tl, p_tc);
            f_ctl.mode  = MODE_IDLE;
          end
        end
        MODE_OPER: begin
          feed_v[0] = 1'b1;
          if (is_pair(p_ctl.held_byte, c)) begin
            feed_tok[0] = make_tok(KIND_DELIM, p_ts, LEN_TWO, p_tl, p_tc);
            f_ctl.mode  = MODE_IDLE;
          end else begin
            feed_tok[0] = make_tok(KIND_DELIM, p_ts, LEN_ONE, p_tl, p_tc);
            to_idle     = 1'b1;
          end
        end
        MODE_WORD: begin
          if ((c == CH_DOT) && p_ctl.prev_digit) begin
            f_ctl.mode = MODE_WORDDOT;
          end else if (is_ws(c) || (c == CH_QUOTE) || is_delim(c)) begin
            feed_v[0]   = 1'b1;
            feed_tok[0] = make_tok(KIND_WORD, p_ts, len_of(p_pos, p_ts), p_tl, p_tc);
            to_idle     = 1'b1;
          end else begin
            f_ctl.prev_digit = is_digit(c);
          end
        end
        MODE_WORDDOT: begin
          if (is_digit(c)) begin
            f_ctl.mode       = MODE_WORD;
            f_ctl.prev_digit = 1'b1;
          end else begin
            feed_v[0]   = 1'b1;
            feed_tok[0] = make_tok(KIND_WORD, p_ts, len_before_dot(dot_of(p_pos), p_ts),
                                   p_tl, p_tc);
            feed_v[1]   = 1'b1;
            feed_tok[1] = make_tok(KIND_DELIM, dot_of(p_pos), LEN_ONE, p_line,
                                   dcol_of(p_col));
            to_idle     = 1'b1;
          end
        end
        default: to_idle = 1'b1;
      endcase

      if (to_idle) begin
        f_ctl.mode = MODE_IDLE;
        if (c == CH_SLASH) begin
          f_ts = p_pos;
          f_tl = p_line;
          f_tc = p_col;
          f_ctl.mode = MODE_SLASH;
        end else if (c == CH_QUOTE) begin
          f_ts = p_pos;
          f_tl = p_line;
          f_tc = p_col;
          f_ctl.mode = MODE_STRING;
        end else if (is_delim(c)) begin
          if (may_pair(c)) begin
            f_ts = p_pos;
            f_tl = p_line;
            f_tc = p_col;
            f_ctl.held_byte = c;
            f_ctl.mode      = MODE_OPER;
          end else begin
            feed_v[2]   = 1'b1;
            feed_tok[2] = make_tok(KIND_DELIM, p_pos, LEN_ONE, p_line, p_col);
          end
        end else if (!is_ws(c)) begin
          f_ts = p_pos;
          f_tl = p_line;
          f_tc = p_col;
          f_ctl.prev_digit = is_digit(c);
          f_ctl.mode       = MODE_WORD;
        end
      end

      f_pos = sat_inc(p_pos);
      if (c == CH_LF) begin
        f_line = sat_inc(p_line);
        f_col  = CW'(1);
      end else begin
        f_col = sat_inc(p_col);
      end
    end
  end

  // Flush at the last byte: pending token, then the end item or the error item.
  always_comb begin : finish_outputs
    for (int j = 0; j < SLOTS; j++) begin
      fin_tok[j] = '0;
      fin_v[j]   = 1'b0;
    end
    if (item.final_byte) begin
      case (f_ctl.mode)
        MODE_WORD: begin
          fin_v[0]   = 1'b1;
          fin_tok[0] = make_tok(KIND_WORD, f_ts, len_of(f_pos, f_ts), f_tl, f_tc);
        end
        MODE_WORDDOT: begin
          fin_v[0]   = 1'b1;
          fin_tok[0] = make_tok(KIND_WORD, f_ts, len_before_dot(dot_of(f_pos), f_ts),
                                f_tl, f_tc);
          fin_v[1]   = 1'b1;
          fin_tok[1] = make_tok(KIND_DELIM, dot_of(f_pos), LEN_ONE, f_line, dcol_of(f_col));
        end
        MODE_OPER, MODE_SLASH: begin
          fin_v[0]   = 1'b1;
          fin_tok[0] = make_tok(KIND_DELIM, f_ts, LEN_ONE, f_tl, f_tc);
        end
        MODE_STRING: begin
          fin_v[0]   = 1'b1;
          fin_tok[0] = make_tok(KIND_ERROR, f_ts, len_of(f_pos, f_ts), f_tl, f_tc);
        end
        default: fin_v[0] = 1'b0;
      endcase
      fin_v[2]   = (f_ctl.mode != MODE_STRING);
      fin_tok[2] = make_tok(KIND_END, f_pos, '0, f_line, f_col);
    end
  end

  // After the last byte the scanner rewinds so that a new source can follow.
  always_comb begin : state_next
    if (item.final_byte) begin
      ctl_next       = STL_CTL_RESET;
      pos_next       = '0;
      line_next      = CW'(1);
      col_next       = CW'(1);
      tok_start_next = '0;
      tok_line_next  = CW'(1);
      tok_col_next   = CW'(1);
    end else begin
      ctl_next       = f_ctl;
      pos_next       = f_pos;
      line_next      = f_line;
      col_next       = f_col;
      tok_start_next = f_ts;
      tok_line_next  = f_tl;
      tok_col_next   = f_tc;
    end
  end

  // Pack the released tokens in order into the front of the result list.
  always_comb begin : compact
    logic [STL_COUNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < STL_MAX_RESULTS; i++) begin
      results[i] = '0;
    end
    for (int j = 0; j < SLOTS; j++) begin
      if (feed_v[j]) begin
        results[STL_INDEX_W'(n)] = feed_tok[j];
        n = n + STL_COUNT_W'(1);
      end
    end
    for (int j = 0; j < SLOTS; j++) begin
      if (fin_v[j]) begin
        results[STL_INDEX_W'(n)] = fin_tok[j];
        n = n + STL_COUNT_W'(1);
      end
    end
    result_count = n;
  end

endmodule

// File: src/source_text_lexer_core.sv
`timescale 1ns / 1ps
// Top level of the streaming source text lexer: byte input, token output.
// Depends on stl_pkg, stl_chan_if and stl_step.

// The lexer takes one source byte per item on char_stream and delivers token
// descriptors (kind, offset, length, line, column) on token_stream. A byte
// that releases no token or one token does not hold the input, so plain text
// streams at one byte per clock while token_stream is ready. A byte that
// releases several tokens (at most four, when a final byte flushes pending tokens and
// adds the end item) holds the input until they have drained, because the
// tokens leave through the single result port one per clock when token_stream
// is ready. The first token that a byte releases passes the input register,
// the token batch register and the output register before it is offered on
// token_stream. The last token that a byte releases carries run_end. After a
// final byte the scanner returns to its reset state, so the next byte starts a
// new source, again beginning with the byte order mark check.
module source_text_lexer_core import stl_pkg::*; #(
  parameter longint unsigned SOURCE_BYTES = STL_SOURCE_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  stl_chan_if.sink   char_stream,
  stl_chan_if.source token_stream
);

  localparam int CW = stl_count_width(SOURCE_BYTES);

  // Input register.
  logic    in_full;
  stl_in_t in_item;

  // Scanner state.
  stl_ctl_t      ctl;
  logic [CW-1:0] pos, line, col, tok_start, tok_line, tok_col;

  // Next scanner state and the tokens released by the byte in the input register.
  stl_ctl_t               ctl_next;
  logic [CW-1:0]          pos_next, line_next, col_next;
  logic [CW-1:0]          tok_start_next, tok_line_next, tok_col_next;
  stl_token_t             step_results [STL_MAX_RESULTS];
  logic [STL_COUNT_W-1:0] step_count;

  // Token batch of the last scanned byte, drained one token per cycle while the output can take it.
  stl_token_t             batch [STL_MAX_RESULTS];
  logic [STL_COUNT_W-1:0] batch_count;
  logic [STL_INDEX_W-1:0] batch_idx;

  // Output register.
  logic       out_full;
  stl_token_t out_tok;

  logic       pop;
  logic       last_pop;
  logic       batch_free;
  logic       step_go;
  stl_token_t pop_tok;

  stl_step #(
    .SOURCE_BYTES (SOURCE_BYTES)
  ) u_step (
    .item           (in_item),
    .ctl            (ctl),
    .pos            (pos),
    .line           (line),
    .col            (col),
    .tok_start      (tok_start),
    .tok_line       (tok_line),
    .tok_col        (tok_col),
    .ctl_next       (ctl_next),
    .pos_next       (pos_next),
    .line_next      (line_next),
    .col_next       (col_next),
    .tok_start_next (tok_start_next),
    .tok_line_next  (tok_line_next),
    .tok_col_next   (tok_col_next),
    .results        (step_results),
    .result_count   (step_count)
  );

  // A token moves from the batch to the output register whenever the output
  // register is empty or is being emptied this cycle.
  assign pop      = (batch_count != '0) && (!out_full || token_stream.ready);
  assign last_pop = pop &&
                    (STL_COUNT_W'(batch_idx) == batch_count - STL_COUNT_W'(1));

  // The byte in the input register is scanned as soon as the batch is empty or
  // hands over its last token in this cycle, so scanning and draining overlap.
  assign batch_free = (batch_count == '0) || last_pop;
  assign step_go    = in_full && batch_free;

  assign char_stream.ready = !in_full || step_go;

  always_comb begin
    pop_tok         = batch[batch_idx];
    pop_tok.run_end = last_pop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (char_stream.valid && char_stream.ready) begin
      in_full <= 1'b1;
    end else if (step_go) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_stream.valid && char_stream.ready) begin
      in_item <= char_stream.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl       <= STL_CTL_RESET;
      pos       <= '0;
      line      <= CW'(1);
      col       <= CW'(1);
      tok_start <= '0;
      tok_line  <= CW'(1);
      tok_col   <= CW'(1);
    end else if (step_go) begin
      ctl       <= ctl_next;
      pos       <= pos_next;
      line      <= line_next;
      col       <= col_next;
      tok_start <= tok_start_next;
      tok_line  <= tok_line_next;
      tok_col   <= tok_col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_count <= '0;
      batch_idx   <= '0;
    end else if (step_go) begin
      batch_count <= step_count;
      batch_idx   <= '0;
    end else if (last_pop) begin
      batch_count <= '0;
      batch_idx   <= '0;
    end else if (pop) begin
      batch_idx <= batch_idx + STL_INDEX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      batch <= step_results;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (pop) begin
      out_full <= 1'b1;
    end else if (token_stream.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_tok <= pop_tok;
    end
  end

  assign token_stream.valid = out_full;
  assign token_stream.data  = out_tok;

`ifndef SYNTH
  // The drain index always points at a token that is still in the batch.
  a_batch_index: assert property (@(posedge clk) disable iff (rst)
    batch_count != '0 |->
      (STL_COUNT_W'(batch_idx) < batch_count) &&
      (batch_count <= STL_COUNT_W'(STL_MAX_RESULTS)))
    else $error("token batch index outside the batch");

  // A final byte always releases at least the end item or the error item.
  a_final_releases: assert property (@(posedge clk) disable iff (rst)
    step_go && in_item.final_byte |=> batch_count != '0)
    else $error("final byte released no token");

  // After a final byte the scanner is back at the byte order mark check.
  a_final_rewinds: assert property (@(posedge clk) disable iff (rst)
    step_go && in_item.final_byte |=> (ctl.mode == MODE_MARK) && (pos == '0))
    else $error("scanner did not rewind after the final byte");

  // The end item and the error item close a byte's run of tokens.
  a_closing_item_last: assert property (@(posedge clk) disable iff (rst)
    token_stream.valid &&
    ((token_stream.data.token_kind == KIND_END) ||
     (token_stream.data.token_kind == KIND_ERROR)) |->
      token_stream.data.run_end)
    else $error("end or error item is not the last of its run");
`endif

endmodule
